// ===== design/bounded_stack_with_search_macros.svh =====
// ----------------------------------------------------------------------------
// bounded_stack_with_search_macros.svh
// Assertion macros for the stack block; they compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STACK_WITH_SEARCH_MACROS_SVH
`define BOUNDED_STACK_WITH_SEARCH_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define BSWS_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsws assertion failed");
// next-cycle implication
`define BSWS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsws assertion failed");
`else
`define BSWS_ASSERT_NOW(name, clk, rst, ante, cons)
`define BSWS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== design/bsws_pkg.sv =====
// ----------------------------------------------------------------------------
// bsws_pkg
// Shared types and codes for the bounded stack with search.
// ----------------------------------------------------------------------------
`default_nettype none

package bsws_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int WORD_W        = 32;
  localparam int POS_W         = 6;
  localparam int CNT_W         = 7;
  localparam int POS_MAX       = 63;
  localparam int CNT_MAX       = 127;

  // request codes
  localparam logic [1:0] REQ_PUSH   = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_NOTFOUND  = 2'd3;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_SEARCH,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [WORD_W-1:0] push_value;
    logic signed [WORD_W-1:0] search_key;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] popped_value;
    logic                     found;
    logic [POS_W-1:0]         found_position;
    logic                     is_empty;
    logic                     is_full;
    logic [CNT_W-1:0]         entry_count;
  } rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] operand;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/bsws_ram.sv =====
// ----------------------------------------------------------------------------
// bsws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/bsws_front.sv =====
// ----------------------------------------------------------------------------
// bsws_front
// Takes requests, decodes them into commands and queues them (2 deep).
// ----------------------------------------------------------------------------
`default_nettype none

module bsws_front
  import bsws_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t request,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  wire logic cmd_ready
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_cnt;
  logic [1:0] q_cnt_next;
  cmd_t       decoded;
  logic       take;
  logic       give;

  always_comb begin
    decoded = '{op: OP_NOP, operand: '0};
    unique case (request.req_type)
      REQ_PUSH:   decoded = '{op: OP_PUSH, operand: request.push_value};
      REQ_POP:    decoded = '{op: OP_POP, operand: '0};
      REQ_SEARCH: decoded = '{op: OP_SEARCH, operand: request.search_key};
      default:    decoded = '{op: OP_NOP, operand: '0};
    endcase
  end

  assign busy      = (q_cnt == 2'd2);
  assign cmd_valid = (q_cnt != 2'd0);
  assign cmd       = q[rd_ptr];
  assign take      = start && !busy;
  assign give      = cmd_valid && cmd_ready;

  always_comb begin
    q_cnt_next = q_cnt;
    if (take && !give) begin
      q_cnt_next = q_cnt + 2'd1;
    end else if (give && !take) begin
      q_cnt_next = q_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q[wr_ptr] <= decoded;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (take) begin
        wr_ptr <= !wr_ptr;
      end
      if (give) begin
        rd_ptr <= !rd_ptr;
      end
      q_cnt <= q_cnt_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/bsws_back.sv =====
// ----------------------------------------------------------------------------
// bsws_back
// Executes commands against the stack store and registers one result each.
// ----------------------------------------------------------------------------
`default_nettype none

module bsws_back
  import bsws_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  output logic      done,
  output rsp_t      result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SRCH
  } state_t;

  state_t            state;
  logic [CW-1:0]     cnt;
  logic [WORD_W-1:0] key;
  logic [CW-1:0]     issue_d;   // next distance to read
  logic              pend;      // a read is in flight
  logic [AW-1:0]     pend_d;    // its distance from top

  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [WORD_W-1:0] rdata;
  logic              hit;

  function automatic rsp_t make_rsp(logic [1:0] st, logic [WORD_W-1:0] popped,
                                    logic fnd, logic [AW-1:0] dpos,
                                    logic [CW-1:0] n);
    rsp_t r;
    r.status         = st;
    r.popped_value   = $signed(popped);
    r.found          = fnd;
    r.found_position = (32'(dpos) > 32'(POS_MAX)) ? POS_W'(POS_MAX) : POS_W'(dpos);
    r.is_empty       = (n == '0);
    r.is_full        = (n == CW'(DEPTH));
    r.entry_count    = (32'(n) > 32'(CNT_MAX)) ? CNT_W'(CNT_MAX) : CNT_W'(n);
    return r;
  endfunction

  bsws_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cmd.operand),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cmd_ready = (state == S_IDLE);
  assign waddr     = AW'(cnt);
  assign we        = (state == S_IDLE) && cmd_valid && (cmd.op == OP_PUSH) &&
                     (cnt != CW'(DEPTH));
  assign hit       = pend && (rdata == key);

  always_comb begin
    raddr = '0;
    unique case (state)
      S_IDLE:  raddr = AW'(cnt - CW'(1));
      S_SRCH:  raddr = AW'(cnt - CW'(1) - issue_d);
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      done    <= 1'b0;
      pend    <= 1'b0;
      issue_d <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.op)
              OP_PUSH: begin
                done <= 1'b1;
                if (cnt == CW'(DEPTH)) begin
                  result <= make_rsp(ST_OVERFLOW, '0, 1'b0, '0, cnt);
                end else begin
                  cnt    <= cnt + CW'(1);
                  result <= make_rsp(ST_OK, '0, 1'b0, '0, cnt + CW'(1));
                end
              end
              OP_POP: begin
                if (cnt == '0) begin
                  done   <= 1'b1;
                  result <= make_rsp(ST_UNDERFLOW, '0, 1'b0, '0, cnt);
                end else begin
                  state <= S_POP;   // top word read in flight
                end
              end
              OP_SEARCH: begin
                key     <= cmd.operand;
                issue_d <= '0;
                pend    <= 1'b0;
                state   <= S_SRCH;
              end
              default: begin
                done   <= 1'b1;
                result <= make_rsp(ST_OK, '0, 1'b0, '0, cnt);
              end
            endcase
          end
        end
        S_POP: begin
          cnt    <= cnt - CW'(1);
          done   <= 1'b1;
          result <= make_rsp(ST_OK, rdata, 1'b0, '0, cnt - CW'(1));
          state  <= S_IDLE;
        end
        S_SRCH: begin
          priority if (hit) begin
            done   <= 1'b1;
            pend   <= 1'b0;
            result <= make_rsp(ST_OK, '0, 1'b1, pend_d, cnt);
            state  <= S_IDLE;
          end else if (issue_d < cnt) begin
            pend    <= 1'b1;
            pend_d  <= AW'(issue_d);
            issue_d <= issue_d + CW'(1);
          end else begin
            done   <= 1'b1;
            pend   <= 1'b0;
            result <= make_rsp(ST_NOTFOUND, '0, 1'b0, '0, cnt);
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/bounded_stack_with_search.sv =====
// Push and unused codes complete from the idle state; pop passes through S_POP; search
//   compares k entries from the top, where k <= count, using the one read port.
//   The request queue takes new items while the back still works on an earlier one.
// Reset (rst, synchronous, high) empties the stack and the request queue; the
//   store itself is not cleared. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// bounded_stack_with_search
// LIFO of signed words with push, pop and top-down linear search.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_stack_with_search_macros.svh"

module bounded_stack_with_search
  import bsws_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t request,
  output logic      done,
  output rsp_t      result
);

  // Front: decodes each item into a command and holds up to two of them,
  // so new items are taken while the back is still walking a search.
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  bsws_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  // Back: owns the count and the store. Push writes at the count; pop reads
  // the top word (registered read, taken in S_POP); search reads one entry
  // per cycle from the top, comparing each word in the cycle after its read.
  bsws_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .done      (done),
    .result    (result)
  );

  // an accepted item is waiting in the queue on the next cycle at least
  `BSWS_ASSERT_NEXT(a_queue_holds, clk, rst, start && !busy, cmd_valid)
  // a hit always reports ok
  `BSWS_ASSERT_NOW(a_found_ok, clk, rst, done && result.found, result.status == ST_OK)
  // a dropped push only happens on a full stack
  `BSWS_ASSERT_NOW(a_ovf_full, clk, rst, done && result.status == ST_OVERFLOW,
                   result.is_full)
  // underflow leaves the stack empty and returns zero
  `BSWS_ASSERT_NOW(a_unf_empty, clk, rst, done && result.status == ST_UNDERFLOW,
                   result.is_empty && result.popped_value == '0)

endmodule

`default_nettype wire
